// ----- design/tsp_pkg.sv -----
`timescale 1ns / 1ps
package tsp_pkg;

  localparam int WORD_BYTES  = 8;
  localparam int WORD_W      = 8 * WORD_BYTES;
  localparam int FRAME_WORDS = 7;
  localparam int IDX_W       = 3;
  localparam int VB_W        = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int SUM_W       = 19;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_WORDS - 1);
  localparam logic [VB_W-1:0]  FULL_VB   = VB_W'(WORD_BYTES);
  localparam logic [VB_W-1:0]  TAIL_VB   = VB_W'(54 - (FRAME_WORDS - 1) * WORD_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_GW_MAC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IP_IDENT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TTL         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd6;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] TCP_LEN        = 16'd20;
  localparam logic [7:0]  TCP_DOFF       = 8'h50;
  localparam logic [7:0]  TCP_FLAG_SYN   = 8'h02;

  typedef struct packed {
    logic [47:0] gw_mac;
    logic [47:0] source_mac;
    logic [31:0] own_ip;
    logic [15:0] source_port;
    logic [15:0] ip_ident;
    logic [7:0]  time_to_live;
    logic [15:0] window_size;
  } tsp_cfg_t;

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } tsp_hdr_t;

  function automatic logic [15:0] fold_not(input logic [SUM_W-1:0] s);
    logic [16:0] a;
    logic [15:0] b;
    a = {1'b0, s[15:0]} + 17'(s[SUM_W-1:16]);
    b = a[15:0] + 16'(a[16]);
    return ~b;
  endfunction

endpackage

// ----- design/tsp_if.sv -----
`timescale 1ns / 1ps
interface tsp_probe_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;
  modport source (output valid, dest_ip, dest_port, input ready);
  modport sink (input valid, dest_ip, dest_port, output ready);
endinterface

interface tsp_frame_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic [2:0]  word_index;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, frame_word, word_index, valid_bytes, last_word, input ready);
  modport sink (input valid, frame_word, word_index, valid_bytes, last_word, output ready);
endinterface

interface tsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/tsp_cfg_regs.sv -----
`timescale 1ns / 1ps
module tsp_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  tsp_cfg_if.sink           cfg,
  output tsp_pkg::tsp_cfg_t regs
);
  import tsp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gw_mac       <= 48'hFFFF_FFFF_FFFF;
      regs.source_mac   <= '0;
      regs.own_ip       <= '0;
      regs.source_port  <= 16'd12345;
      regs.ip_ident     <= 16'd12345;
      regs.time_to_live <= 8'd64;
      regs.window_size  <= 16'd5840;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GW_MAC:      regs.gw_mac       <= cfg.data;
        REG_SOURCE_MAC:  regs.source_mac   <= cfg.data;
        REG_OWN_IP:      regs.own_ip       <= cfg.data[31:0];
        REG_SOURCE_PORT: regs.source_port  <= cfg.data[15:0];
        REG_IP_IDENT:    regs.ip_ident     <= cfg.data[15:0];
        REG_TTL:         regs.time_to_live <= cfg.data[7:0];
        REG_WINDOW:      regs.window_size  <= cfg.data[15:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- design/tsp_csum_pipe.sv -----
`timescale 1ns / 1ps
module tsp_csum_pipe (
  input  logic              clk,
  input  logic              rst,
  input  tsp_pkg::tsp_cfg_t regs,
  tsp_probe_if.sink         probe,
  output logic              hdr_valid,
  input  logic              hdr_ready,
  output tsp_pkg::tsp_hdr_t hdr
);
  import tsp_pkg::*;

  // stage 1: partial sums
  logic        v1;
  logic [31:0] dip1;
  logic [15:0] dport1;
  logic [17:0] addr_sum1, ip_part1, tcp_part1;
  // stage 2: full sums
  logic        v2;
  logic [31:0] dip2;
  logic [15:0] dport2;
  logic [SUM_W-1:0] ip_sum2, tcp_sum2;

  logic adv1, adv2, adv3;

  assign adv3        = !hdr_valid || hdr_ready;
  assign adv2        = !v2 || adv3;
  assign adv1        = !v1 || adv2;
  assign probe.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      hdr_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= probe.valid;
      if (adv2) v2 <= v1;
      if (adv3) hdr_valid <= v2;
    end
    if (adv1) begin
      dip1      <= probe.dest_ip;
      dport1    <= probe.dest_port;
      addr_sum1 <= 18'(regs.own_ip[31:16]) + 18'(regs.own_ip[15:0])
                 + 18'(probe.dest_ip[31:16]) + 18'(probe.dest_ip[15:0]);
      ip_part1  <= 18'({IP_VER_IHL, 8'h00}) + 18'(IP_TOTAL_LEN) + 18'(regs.ip_ident)
                 + 18'({regs.time_to_live, PROTO_TCP});
      tcp_part1 <= 18'({8'h00, PROTO_TCP}) + 18'(TCP_LEN) + 18'({TCP_DOFF, TCP_FLAG_SYN})
                 + 18'(regs.source_port) + 18'(probe.dest_port)
                 + 18'(regs.window_size);
    end
    if (adv2) begin
      dip2     <= dip1;
      dport2   <= dport1;
      ip_sum2  <= SUM_W'(addr_sum1) + SUM_W'(ip_part1);
      tcp_sum2 <= SUM_W'(addr_sum1) + SUM_W'(tcp_part1);
    end
    if (adv3) begin
      hdr.dest_ip   <= dip2;
      hdr.dest_port <= dport2;
      hdr.ip_csum   <= fold_not(ip_sum2);
      hdr.tcp_csum  <= fold_not(tcp_sum2);
    end
  end

`ifndef SYNTHESIS
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr))
    else $error("stalled header changed");
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv3 |=> v2 && $stable(ip_sum2))
    else $error("stage 2 lost data under stall");
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && hdr_valid && !hdr_ready |-> !probe.ready)
    else $error("request taken into full pipeline");
`endif
endmodule

// ----- design/tsp_serializer.sv -----
`timescale 1ns / 1ps
module tsp_serializer (
  input  logic              clk,
  input  logic              rst,
  input  tsp_pkg::tsp_cfg_t regs,
  input  logic              hdr_valid,
  output logic              hdr_ready,
  input  tsp_pkg::tsp_hdr_t hdr,
  tsp_frame_if.source       frame
);
  import tsp_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] cnt;
  tsp_hdr_t         h;
  logic             take_last;
  logic [WORD_W-1:0] word;

  assign take_last = busy && frame.ready && (cnt == LAST_IDX);
  assign hdr_ready = !busy || take_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (hdr_valid && hdr_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (take_last) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (busy && frame.ready) begin
      cnt <= cnt + IDX_W'(1);
    end
    if (hdr_valid && hdr_ready) h <= hdr;
  end

  always_comb begin
    case (cnt)
      3'd0: word = {regs.gw_mac, regs.source_mac[47:32]};
      3'd1: word = {regs.source_mac[31:0], ETHERTYPE_IPV4, IP_VER_IHL, 8'h00};
      3'd2: word = {IP_TOTAL_LEN, regs.ip_ident, 16'h0000, regs.time_to_live, PROTO_TCP};
      3'd3: word = {h.ip_csum, regs.own_ip, h.dest_ip[31:16]};
      3'd4: word = {h.dest_ip[15:0], regs.source_port, h.dest_port, 16'h0000};
      3'd5: word = {48'h0, TCP_DOFF, TCP_FLAG_SYN};
      3'd6: word = {regs.window_size, h.tcp_csum, 32'h0};
      default: word = '0;
    endcase
  end

  assign frame.valid       = busy;
  assign frame.frame_word  = word;
  assign frame.word_index  = cnt;
  assign frame.last_word   = (cnt == LAST_IDX);
  assign frame.valid_bytes = (cnt == LAST_IDX) ? TAIL_VB : FULL_VB;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_IDX)
    else $error("word counter out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !frame.ready |=> busy && $stable(cnt) && $stable(h))
    else $error("frame word moved while stalled");
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_ready |=> busy && cnt == '0)
    else $error("new frame did not start at word zero");
`endif
endmodule

// ----- design/tcp_syn_probe_frame_builder.sv -----
`timescale 1ns / 1ps
// channel  dir  payload                                         request
// probe    in   dest_ip[32] dest_port[16]                       one SYN probe
// frame    out  frame_word[64] word_index[3] valid_bytes[4]     one frame word
//               last_word[1]
// cfg      in   index[3] data[48]                               one register write
//
// Each request yields 7 frame words, one per cycle while frame is ready. The single
// word serializer takes the next request when idle or as it sends the last word.
// A request passes 3 checksum stages, then the serializer, before word 0 appears.
// Requests enter back to back; the checksum pipe holds up to 3 more behind a frame.
// rst is synchronous; registers return to their defaults, pipe and serializer empty.
// A stall on frame holds the current word and backs up the pipe; nothing is lost.
module tcp_syn_probe_frame_builder (
  input  logic      clk,
  input  logic      rst,
  tsp_probe_if.sink probe,
  tsp_frame_if.source frame,
  tsp_cfg_if.sink   cfg
);
  import tsp_pkg::*;

  tsp_cfg_t regs;
  tsp_hdr_t hdr;
  logic     hdr_valid, hdr_ready;

  tsp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tsp_csum_pipe u_csum (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .probe     (probe),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr)
  );

  tsp_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr),
    .frame     (frame)
  );
endmodule

// ----- verif/tb_tcp_syn_probe_frame_builder.sv -----
`timescale 1ns / 1ps
module tb_tcp_syn_probe_frame_builder;
  import tsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES    = 12;
  localparam int RANDOM_PER_PHASE = 40;
  localparam int RESET_CYCLES     = 7;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [2:0]  word_index;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } syn_word_t;

  logic clk = 1'b0;
  logic rst;

  tsp_probe_if probe_if();
  tsp_frame_if frame_if();
  tsp_cfg_if   cfg_if();

  tsp_cfg_t  cfg_shadow;
  syn_word_t pending_words[$];
  int        mismatch_count = 0;
  int        snd_idle_pct = 0;
  int        rcv_idle_pct = 0;

  tcp_syn_probe_frame_builder dut (
    .clk   (clk),
    .rst   (rst),
    .probe (probe_if),
    .frame (frame_if),
    .cfg   (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[tcp_syn_probe_frame_builder] ERROR");
    $finish;
  end

  function automatic logic [15:0] fold_complement(input logic [31:0] s);
    logic [31:0] t;
    t = (s >> 16) + (s & 32'h0000_FFFF);
    t = t + (t >> 16);
    return ~t[15:0];
  endfunction

  // expected seven words of one SYN frame under the current register values
  function automatic void predict_syn_frame(input logic [31:0] dip, input logic [15:0] dport);
    logic [31:0]  acc;
    logic [15:0]  ip_csum;
    logic [15:0]  tcp_csum;
    logic [447:0] frame_bits;
    syn_word_t    w;
    acc = 32'({IP_VER_IHL, 8'h00}) + 32'(IP_TOTAL_LEN) + 32'(cfg_shadow.ip_ident)
        + 32'({cfg_shadow.time_to_live, PROTO_TCP})
        + 32'(cfg_shadow.own_ip[31:16]) + 32'(cfg_shadow.own_ip[15:0])
        + 32'(dip[31:16]) + 32'(dip[15:0]);
    ip_csum = fold_complement(acc);
    // pseudo-header, then TCP header
    acc = 32'(cfg_shadow.own_ip[31:16]) + 32'(cfg_shadow.own_ip[15:0])
        + 32'(dip[31:16]) + 32'(dip[15:0]) + 32'({8'h00, PROTO_TCP}) + 32'(TCP_LEN)
        + 32'(cfg_shadow.source_port) + 32'(dport) + 32'({TCP_DOFF, TCP_FLAG_SYN})
        + 32'(cfg_shadow.window_size);
    tcp_csum = fold_complement(acc);
    frame_bits = {cfg_shadow.gw_mac, cfg_shadow.source_mac, ETHERTYPE_IPV4,
                  IP_VER_IHL, 8'h00, IP_TOTAL_LEN, cfg_shadow.ip_ident, 16'h0000,
                  cfg_shadow.time_to_live, PROTO_TCP, ip_csum,
                  cfg_shadow.own_ip, dip,
                  cfg_shadow.source_port, dport, 32'h0, 32'h0,
                  TCP_DOFF, TCP_FLAG_SYN, cfg_shadow.window_size, tcp_csum, 16'h0000,
                  16'h0000};
    for (int k = 0; k < FRAME_WORDS; k++) begin
      w.frame_word  = frame_bits[447 - 64 * k -: 64];
      w.word_index  = IDX_W'(k);
      w.valid_bytes = (w.word_index == LAST_IDX) ? TAIL_VB : FULL_VB;
      w.last_word   = (w.word_index == LAST_IDX);
      pending_words.push_back(w);
    end
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_GW_MAC:      cfg_shadow.gw_mac       = value;
      REG_SOURCE_MAC:  cfg_shadow.source_mac   = value;
      REG_OWN_IP:      cfg_shadow.own_ip       = value[31:0];
      REG_SOURCE_PORT: cfg_shadow.source_port  = value[15:0];
      REG_IP_IDENT:    cfg_shadow.ip_ident     = value[15:0];
      REG_TTL:         cfg_shadow.time_to_live = value[7:0];
      REG_WINDOW:      cfg_shadow.window_size  = value[15:0];
      default: begin
      end
    endcase
  endfunction

  task automatic send_probe(input logic [31:0] ip, input logic [15:0] port);
    while ($urandom_range(99) < snd_idle_pct) begin
      probe_if.valid <= 1'b0;
      @(posedge clk);
    end
    probe_if.valid     <= 1'b1;
    probe_if.dest_ip   <= ip;
    probe_if.dest_port <= port;
    @(posedge clk);
    while (!probe_if.ready) @(posedge clk);
    predict_syn_frame(ip, port);
  endtask

  task automatic drain_frames;
    probe_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg_write(idx, value);
  endtask

  task automatic program_config(input logic [47:0] dmac, input logic [47:0] smac,
                                input logic [47:0] sip, input logic [47:0] sport,
                                input logic [47:0] ident, input logic [47:0] ttl,
                                input logic [47:0] win);
    write_reg(REG_GW_MAC, dmac);
    write_reg(REG_SOURCE_MAC, smac);
    write_reg(REG_OWN_IP, sip);
    write_reg(REG_SOURCE_PORT, sport);
    write_reg(REG_IP_IDENT, ident);
    write_reg(REG_TTL, ttl);
    write_reg(REG_WINDOW, win);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults;
    send_probe(32'h0000_0000, 16'h0000);
    send_probe(32'hFFFF_FFFF, 16'hFFFF);
    send_probe(32'hC0A8_0001, 16'd80);
    send_probe(32'h8000_0001, 16'h8000);
    drain_frames();
  endtask

  task automatic test_register_extremes;
    program_config(48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0);
    send_probe(32'h0000_0000, 16'h0000);
    send_probe(32'hFFFF_FFFF, 16'hFFFF);
    send_probe($urandom, 16'($urandom));
    drain_frames();
    // all ones also checks that upper bits of narrow registers are dropped
    program_config('1, '1, '1, '1, '1, '1, '1);
    send_probe(32'h0000_0000, 16'h0000);
    send_probe(32'hFFFF_FFFF, 16'hFFFF);
    send_probe($urandom, 16'($urandom));
    drain_frames();
    write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
    cfg_if.valid <= 1'b0;
    send_probe($urandom, 16'($urandom));
    drain_frames();
    write_reg(REG_TTL, 48'hABCD_EF12_3456);
    write_reg(REG_SOURCE_PORT, 48'({$urandom, $urandom}));
    cfg_if.valid <= 1'b0;
    send_probe($urandom, 16'($urandom));
    send_probe($urandom, 16'($urandom));
    drain_frames();
  endtask

  task automatic test_random_traffic;
    logic [31:0] ip;
    logic [15:0] port;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 16;
          rcv_idle_pct = 69;
        end
        1: begin
          snd_idle_pct = 69;
          rcv_idle_pct = 16;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      program_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}));
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (ph == 0 && n == RANDOM_PER_PHASE / 2) drain_frames();
        case ($urandom_range(9))
          0: ip = 32'h0000_0000;
          1: ip = 32'hFFFF_FFFF;
          default: ip = $urandom;
        endcase
        case ($urandom_range(9))
          0: port = 16'h0000;
          1: port = 16'hFFFF;
          default: port = 16'($urandom);
        endcase
        send_probe(ip, port);
      end
      drain_frames();
    end
  endtask

  // frame sink: random backpressure and per-field check against oldest expectation
  initial begin
    syn_word_t exp_w;
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
        if (frame_if.valid && frame_if.ready) begin
          if (pending_words.size() == 0) begin
            $error("frame word %h with no request pending", frame_if.frame_word);
            mismatch_count++;
          end else begin
            exp_w = pending_words.pop_front();
            if (frame_if.frame_word !== exp_w.frame_word) begin
              $error("frame_word: expected %h, got %h", exp_w.frame_word, frame_if.frame_word);
              mismatch_count++;
            end
            if (frame_if.word_index !== exp_w.word_index) begin
              $error("word_index: expected %0d, got %0d", exp_w.word_index, frame_if.word_index);
              mismatch_count++;
            end
            if (frame_if.valid_bytes !== exp_w.valid_bytes) begin
              $error("valid_bytes: expected %0d, got %0d", exp_w.valid_bytes,
                     frame_if.valid_bytes);
              mismatch_count++;
            end
            if (frame_if.last_word !== exp_w.last_word) begin
              $error("last_word: expected %0b, got %0b", exp_w.last_word, frame_if.last_word);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    probe_if.valid     <= 1'b0;
    probe_if.dest_ip   <= '0;
    probe_if.dest_port <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    cfg_shadow.gw_mac       = 48'hFFFF_FFFF_FFFF;
    cfg_shadow.source_mac   = 48'h0;
    cfg_shadow.own_ip       = 32'h0;
    cfg_shadow.source_port  = 16'd12345;
    cfg_shadow.ip_ident     = 16'd12345;
    cfg_shadow.time_to_live = 8'd64;
    cfg_shadow.window_size  = 16'd5840;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    drain_frames();
    if (mismatch_count == 0) begin
      $display("[tcp_syn_probe_frame_builder] OK");
    end else begin
      $display("[tcp_syn_probe_frame_builder] ERROR");
    end
    $finish;
  end

endmodule

// ----- tcp_syn_probe_frame_builder.f -----
design/tsp_pkg.sv
design/tsp_if.sv
design/tsp_cfg_regs.sv
design/tsp_csum_pipe.sv
design/tsp_serializer.sv
design/tcp_syn_probe_frame_builder.sv
verif/tb_tcp_syn_probe_frame_builder.sv
